// ===== design/udprat_pkg.sv =====
// Shared types, codes and helpers of the datagram sequence/ack tracker.
// No dependencies; the top level imports this package.
`timescale 1ns / 1ps

package udprat_pkg;

    localparam int SENT_DEPTH_DEF = 64;
    localparam int PEND_DEPTH_DEF = 64;
    localparam int RECV_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF  = 24;

    localparam logic [15:0] HALF_RANGE     = 16'h7FFF;
    localparam logic [15:0] PRUNE_DISTANCE = 16'd34;
    localparam logic [15:0] MAX_BIT_INDEX  = 16'd31;
    localparam logic [22:0] BYTES_MAX      = 23'h7FFFFF;
    localparam logic [6:0]  COUNT_MAX      = 7'd127;
    localparam logic [23:0] RTT_MAX        = 24'hFFFFFF;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_RECV = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_PENDING_TIMEOUT = 3'd0,
        REG_SENT_WINDOW     = 3'd1,
        REG_HEADER_BYTES    = 3'd2,
        REG_LINK_OVERHEAD   = 3'd3,
        REG_RTT_GAIN        = 3'd4
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_S_RD, ST_S_PROC, ST_S_PUSH,
        ST_R_DUP_RD, ST_R_DUP_PROC, ST_R_PUSH,
        ST_R_P_RD, ST_R_P_PROC, ST_R_DIFF, ST_R_MUL, ST_R_APPLY,
        ST_T_S_RD, ST_T_S_PROC, ST_T_P_RD, ST_T_P_PROC,
        ST_T_RL_RD, ST_T_RL_PROC, ST_T_R_RD, ST_T_R_PROC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] length_bytes;
        logic [15:0] rx_sequence;
        logic [15:0] rx_ack;
        logic [31:0] rx_ack_bits;
        logic [23:0] elapsed;
    } item_t;

    typedef struct packed {
        logic [15:0] seq_out;
        logic [15:0] ack_out;
        logic [31:0] ack_bits_out;
        logic        payload_present;
        logic        duplicate;
        logic [6:0]  lost_this_tick;
        logic [23:0] rtt;
        logic [22:0] sent_bytes_window;
        logic [6:0]  sent_packets_window;
        logic [31:0] acked_total;
        logic [31:0] lost_total;
    } result_t;

    // a is newer than b on the 16-bit wrapping sequence circle
    function automatic logic more_recent(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] dab;
        logic [15:0] dba;
        dab = a - b;
        dba = b - a;
        return ((a > b) && (dab <= HALF_RANGE)) || ((b > a) && (dba > HALF_RANGE));
    endfunction

endpackage

// ===== design/udprat_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module udprat_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/udp_reliability_ack_tracker_top.sv =====
// Sequence/ack tracker top level: sequencer, queue RAMs and shared RTT unit.
// Depends on udprat_pkg and udprat_ram.
`timescale 1ns / 1ps

// Usage
//   Command channel: present item while start is high; the transaction is taken
//   when start is high and busy is low. busy stays high until the result.
//   Result channel: result is valid for exactly one cycle with done high; the
//   receiver cannot stall it and must take it in that cycle.
//   Config channel: cfg_valid/cfg_ready (ready is always high), cfg_index
//   picks the register, cfg_data carries the value; write only while idle.
//   Walks: every queue is walked one entry at a time (RAM address state,
//   then data state); done rises as busy falls. Send walks the receive queue
//   for the ack bits. Receive scans the receive queue for a duplicate, then
//   walks the pending queue, with difference, multiply and apply steps per
//   acked entry (shared multiply unit of the RTT filter). Tick walks the sent
//   and pending queues and the dropped receive entries, and skips the receive
//   prune with an empty receive queue. One item at a time.
//   The queue memories are circular buffers with head and count, so reset
//   needs no clearing pass: counts, sequences, RTT and totals return to zero
//   and registers to their reset values at once.
module udp_reliability_ack_tracker_top
    import udprat_pkg::*;
#(
    parameter int SENT_DEPTH = SENT_DEPTH_DEF,
    parameter int PEND_DEPTH = PEND_DEPTH_DEF,
    parameter int RECV_DEPTH = RECV_DEPTH_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int SPW = $clog2(SENT_DEPTH);
    localparam int PPW = $clog2(PEND_DEPTH);
    localparam int RPW = $clog2(RECV_DEPTH);
    localparam int SCW = $clog2(SENT_DEPTH + 1);
    localparam int PCW = $clog2(PEND_DEPTH + 1);
    localparam int RCW = $clog2(RECV_DEPTH + 1);
    localparam int WW0 = (SCW > PCW) ? SCW : PCW;
    localparam int WW  = (WW0 > RCW) ? WW0 : RCW;
    localparam int DW  = (TIME_BITS > 24) ? TIME_BITS : 24;
    localparam int SW  = 16 + TIME_BITS + 17;
    localparam int PW  = 16 + TIME_BITS;
    localparam logic [TIME_BITS-1:0] AGE_MAX = {TIME_BITS{1'b1}};

    // control state
    state_t          state_reg, state_next;
    logic            done_reg, done_next;
    result_t         result_reg, result_next;
    item_t           in_reg, in_next;
    logic [15:0]     seq_cap_reg, seq_cap_next;
    logic [15:0]     local_seq_reg, local_seq_next;
    logic [15:0]     remote_seq_reg, remote_seq_next;
    logic [SPW-1:0]  sent_head_reg, sent_head_next;
    logic [SCW-1:0]  sent_count_reg, sent_count_next;
    logic [PPW-1:0]  pend_head_reg, pend_head_next;
    logic [PCW-1:0]  pend_count_reg, pend_count_next;
    logic [RPW-1:0]  recv_head_reg, recv_head_next;
    logic [RCW-1:0]  recv_count_reg, recv_count_next;
    logic [23:0]     rtt_reg, rtt_next;
    logic [31:0]     acked_reg, acked_next;
    logic [31:0]     lost_reg, lost_next;
    logic [23:0]     timeout_reg, timeout_next;
    logic [23:0]     window_reg, window_next;
    logic [7:0]      hdr_reg, hdr_next;
    logic [7:0]      ovh_reg, ovh_next;
    logic [15:0]     gain_reg, gain_next;

    // walk state
    logic [WW-1:0]   walk_reg, walk_next;
    logic [WW-1:0]   n_reg, n_next;
    logic [SPW-1:0]  s_rp_reg, s_rp_next;
    logic [PPW-1:0]  p_rp_reg, p_rp_next;
    logic [PPW-1:0]  p_wp_reg, p_wp_next;
    logic [RPW-1:0]  r_rp_reg, r_rp_next;
    logic [PCW-1:0]  kept_reg, kept_next;
    logic            dropping_reg, dropping_next;
    logic [31:0]     bits_reg, bits_next;
    logic            dup_reg, dup_next;
    logic [PCW-1:0]  lost_tick_reg, lost_tick_next;
    logic [22:0]     bytes_reg, bytes_next;
    logic [15:0]     floor_reg, floor_next;
    logic [TIME_BITS-1:0] age_reg, age_next;
    logic            dir_reg, dir_next;
    logic [DW-1:0]   diff_reg, diff_next;
    logic [DW+15:0]  prod_reg, prod_next;

    // RAM ports
    logic            s_we, p_we, r_we;
    logic [SPW-1:0]  s_waddr;
    logic [PPW-1:0]  p_waddr;
    logic [RPW-1:0]  r_waddr;
    logic [SW-1:0]   s_wdata, s_rdata;
    logic [PW-1:0]   p_wdata, p_rdata;
    logic [15:0]     r_wdata, r_rdata;

    // helpers
    logic [SPW-1:0]  s_rp_inc, s_head_inc, s_tail;
    logic [PPW-1:0]  p_rp_inc, p_wp_inc, p_head_inc, p_tail;
    logic [RPW-1:0]  r_rp_inc, r_head_inc, r_tail, r_last;
    logic [SCW:0]    s_tail_sum;
    logic [PCW:0]    p_tail_sum;
    logic [RCW:0]    r_tail_sum;
    logic            accept;
    logic [15:0]     p_seq, ack_idx, gen_idx;
    logic            p_hit, gen_stop, r_drop;
    logic [DW:0]     s_age_sum, p_age_sum, rtt_sum;
    logic [TIME_BITS-1:0] s_age_new, p_age_new;
    logic [23:0]     bytes_add;
    logic [DW-1:0]   step;
    logic [16:0]     push_bytes;

    udprat_ram #(.WIDTH(SW), .DEPTH(SENT_DEPTH)) u_sent_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_rp_reg), .rdata(s_rdata)
    );
    udprat_ram #(.WIDTH(PW), .DEPTH(PEND_DEPTH)) u_pend_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_rp_reg), .rdata(p_rdata)
    );
    udprat_ram #(.WIDTH(16), .DEPTH(RECV_DEPTH)) u_recv_ram (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_rp_reg), .rdata(r_rdata)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // wrap pointers of the circular buffers
    always_comb
    begin
        s_rp_inc   = (s_rp_reg == SPW'(SENT_DEPTH - 1)) ? '0 : s_rp_reg + 1'b1;
        s_head_inc = (sent_head_reg == SPW'(SENT_DEPTH - 1)) ? '0 : sent_head_reg + 1'b1;
        p_rp_inc   = (p_rp_reg == PPW'(PEND_DEPTH - 1)) ? '0 : p_rp_reg + 1'b1;
        p_wp_inc   = (p_wp_reg == PPW'(PEND_DEPTH - 1)) ? '0 : p_wp_reg + 1'b1;
        p_head_inc = (pend_head_reg == PPW'(PEND_DEPTH - 1)) ? '0 : pend_head_reg + 1'b1;
        r_rp_inc   = (r_rp_reg == RPW'(RECV_DEPTH - 1)) ? '0 : r_rp_reg + 1'b1;
        r_head_inc = (recv_head_reg == RPW'(RECV_DEPTH - 1)) ? '0 : recv_head_reg + 1'b1;
        s_tail_sum = (SCW+1)'(sent_head_reg) + (SCW+1)'(sent_count_reg);
        p_tail_sum = (PCW+1)'(pend_head_reg) + (PCW+1)'(pend_count_reg);
        r_tail_sum = (RCW+1)'(recv_head_reg) + (RCW+1)'(recv_count_reg);
        s_tail = (s_tail_sum >= (SCW+1)'(SENT_DEPTH))
               ? SPW'(s_tail_sum - (SCW+1)'(SENT_DEPTH)) : SPW'(s_tail_sum);
        p_tail = (p_tail_sum >= (PCW+1)'(PEND_DEPTH))
               ? PPW'(p_tail_sum - (PCW+1)'(PEND_DEPTH)) : PPW'(p_tail_sum);
        r_tail = (r_tail_sum >= (RCW+1)'(RECV_DEPTH))
               ? RPW'(r_tail_sum - (RCW+1)'(RECV_DEPTH)) : RPW'(r_tail_sum);
        r_last = (r_tail == '0) ? RPW'(RECV_DEPTH - 1) : r_tail - 1'b1;
    end

    // per-entry decisions of the walks
    always_comb
    begin
        gen_idx  = remote_seq_reg - 16'd1 - r_rdata;
        gen_stop = (r_rdata == remote_seq_reg) || more_recent(r_rdata, remote_seq_reg);
        p_seq    = p_rdata[PW-1:TIME_BITS];
        ack_idx  = in_reg.rx_ack - 16'd1 - p_seq;
        p_hit    = (p_seq == in_reg.rx_ack)
                || (!more_recent(p_seq, in_reg.rx_ack) && (ack_idx <= MAX_BIT_INDEX)
                    && in_reg.rx_ack_bits[ack_idx[4:0]]);
        r_drop   = !more_recent(r_rdata, floor_reg);
        s_age_sum = (DW+1)'(s_rdata[TIME_BITS+16:17]) + (DW+1)'(in_reg.elapsed);
        s_age_new = (s_age_sum > (DW+1)'(AGE_MAX)) ? AGE_MAX : TIME_BITS'(s_age_sum);
        p_age_sum = (DW+1)'(p_rdata[TIME_BITS-1:0]) + (DW+1)'(in_reg.elapsed);
        p_age_new = (p_age_sum > (DW+1)'(AGE_MAX)) ? AGE_MAX : TIME_BITS'(p_age_sum);
        bytes_add = 24'(bytes_reg) + 24'(s_rdata[16:0]) + 24'(ovh_reg);
        step      = prod_reg[DW+15:16];
        rtt_sum   = dir_reg ? ((DW+1)'(rtt_reg) + (DW+1)'(step))
                            : ((DW+1)'(rtt_reg) - (DW+1)'(step));
        push_bytes = 17'(in_reg.length_bytes) + 17'(hdr_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(item.command))
                        CMD_SEND: state_next = ST_S_RD;
                        CMD_RECV: state_next = ST_R_DUP_RD;
                        CMD_TICK: state_next = ST_T_S_RD;
                        default:  state_next = ST_FIN;
                    endcase
                end
            end
            ST_S_RD:       state_next = (walk_reg == WW'(recv_count_reg)) ? ST_S_PUSH : ST_S_PROC;
            ST_S_PROC:     state_next = gen_stop ? ST_S_PUSH : ST_S_RD;
            ST_S_PUSH:     state_next = ST_FIN;
            ST_R_DUP_RD:   state_next = (walk_reg == WW'(recv_count_reg)) ? ST_R_PUSH
                                                                           : ST_R_DUP_PROC;
            ST_R_DUP_PROC: state_next = (r_rdata == in_reg.rx_sequence) ? ST_FIN : ST_R_DUP_RD;
            ST_R_PUSH:     state_next = ST_R_P_RD;
            ST_R_P_RD:     state_next = (walk_reg == n_reg) ? ST_FIN : ST_R_P_PROC;
            ST_R_P_PROC:   state_next = p_hit ? ST_R_DIFF : ST_R_P_RD;
            ST_R_DIFF:     state_next = ST_R_MUL;
            ST_R_MUL:      state_next = ST_R_APPLY;
            ST_R_APPLY:    state_next = ST_R_P_RD;
            ST_T_S_RD:     state_next = (walk_reg == n_reg) ? ST_T_P_RD : ST_T_S_PROC;
            ST_T_S_PROC:   state_next = ST_T_S_RD;
            ST_T_P_RD:
            begin
                if (walk_reg != n_reg)
                    state_next = ST_T_P_PROC;
                else if (recv_count_reg == '0)
                    state_next = ST_FIN;
                else
                    state_next = ST_T_RL_RD;
            end
            ST_T_P_PROC:   state_next = ST_T_P_RD;
            ST_T_RL_RD:    state_next = ST_T_RL_PROC;
            ST_T_RL_PROC:  state_next = ST_T_R_RD;
            ST_T_R_RD:     state_next = (recv_count_reg == '0) ? ST_FIN : ST_T_R_PROC;
            ST_T_R_PROC:   state_next = r_drop ? ST_T_R_RD : ST_FIN;
            ST_FIN:        state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        done_next       = 1'b0;
        result_next     = result_reg;
        in_next         = in_reg;
        seq_cap_next    = seq_cap_reg;
        local_seq_next  = local_seq_reg;
        remote_seq_next = remote_seq_reg;
        sent_head_next  = sent_head_reg;
        sent_count_next = sent_count_reg;
        pend_head_next  = pend_head_reg;
        pend_count_next = pend_count_reg;
        recv_head_next  = recv_head_reg;
        recv_count_next = recv_count_reg;
        rtt_next        = rtt_reg;
        acked_next      = acked_reg;
        lost_next       = lost_reg;
        timeout_next    = timeout_reg;
        window_next     = window_reg;
        hdr_next        = hdr_reg;
        ovh_next        = ovh_reg;
        gain_next       = gain_reg;
        walk_next       = walk_reg;
        n_next          = n_reg;
        s_rp_next       = s_rp_reg;
        p_rp_next       = p_rp_reg;
        p_wp_next       = p_wp_reg;
        r_rp_next       = r_rp_reg;
        kept_next       = kept_reg;
        dropping_next   = dropping_reg;
        bits_next       = bits_reg;
        dup_next        = dup_reg;
        lost_tick_next  = lost_tick_reg;
        bytes_next      = bytes_reg;
        floor_next      = floor_reg;
        age_next        = age_reg;
        dir_next        = dir_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        s_we = 1'b0; s_waddr = s_rp_reg; s_wdata = s_rdata;
        p_we = 1'b0; p_waddr = p_wp_reg; p_wdata = p_rdata;
        r_we = 1'b0; r_waddr = r_tail;   r_wdata = in_reg.rx_sequence;

        // take a register write
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PENDING_TIMEOUT: timeout_next = cfg_data;
                REG_SENT_WINDOW:     window_next  = cfg_data;
                REG_HEADER_BYTES:    hdr_next     = cfg_data[7:0];
                REG_LINK_OVERHEAD:   ovh_next     = cfg_data[7:0];
                REG_RTT_GAIN:        gain_next    = cfg_data[15:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    in_next        = item;
                    seq_cap_next   = local_seq_reg;
                    walk_next      = '0;
                    r_rp_next      = recv_head_reg;
                    s_rp_next      = sent_head_reg;
                    n_next         = WW'(sent_count_reg);
                    bits_next      = '0;
                    dup_next       = 1'b0;
                    dropping_next  = 1'b1;
                    bytes_next     = '0;
                    lost_tick_next = '0;
                end
            end
            // build the ack bitfield from the received queue
            ST_S_PROC:
            begin
                if (!gen_stop && (gen_idx <= MAX_BIT_INDEX))
                    bits_next = bits_reg | (32'd1 << gen_idx[4:0]);
                walk_next = walk_reg + 1'b1;
                r_rp_next = r_rp_inc;
            end
            // log the packet in both queues, drop oldest when full
            ST_S_PUSH:
            begin
                s_we    = 1'b1;
                s_wdata = {local_seq_reg, {TIME_BITS{1'b0}}, push_bytes};
                if (sent_count_reg == SCW'(SENT_DEPTH))
                begin
                    s_waddr        = sent_head_reg;
                    sent_head_next = s_head_inc;
                end
                else
                begin
                    s_waddr         = s_tail;
                    sent_count_next = sent_count_reg + 1'b1;
                end
                p_we    = 1'b1;
                p_wdata = {local_seq_reg, {TIME_BITS{1'b0}}};
                if (pend_count_reg == PCW'(PEND_DEPTH))
                begin
                    p_waddr        = pend_head_reg;
                    pend_head_next = p_head_inc;
                end
                else
                begin
                    p_waddr         = p_tail;
                    pend_count_next = pend_count_reg + 1'b1;
                end
                local_seq_next = local_seq_reg + 16'd1;
            end
            // duplicate scan
            ST_R_DUP_PROC:
            begin
                if (r_rdata == in_reg.rx_sequence)
                    dup_next = 1'b1;
                walk_next = walk_reg + 1'b1;
                r_rp_next = r_rp_inc;
            end
            // record the sequence and set up the ack walk
            ST_R_PUSH:
            begin
                r_we = 1'b1;
                if (recv_count_reg == RCW'(RECV_DEPTH))
                begin
                    r_waddr        = recv_head_reg;
                    recv_head_next = r_head_inc;
                end
                else
                begin
                    recv_count_next = recv_count_reg + 1'b1;
                end
                if (more_recent(in_reg.rx_sequence, remote_seq_reg))
                    remote_seq_next = in_reg.rx_sequence;
                walk_next = '0;
                n_next    = WW'(pend_count_reg);
                p_rp_next = pend_head_reg;
                p_wp_next = pend_head_reg;
                kept_next = '0;
            end
            ST_R_P_RD:
            begin
                if (walk_reg == n_reg)
                    pend_count_next = kept_reg;
            end
            // keep unacked entries packed toward the head
            ST_R_P_PROC:
            begin
                walk_next = walk_reg + 1'b1;
                p_rp_next = p_rp_inc;
                if (p_hit)
                begin
                    age_next = p_rdata[TIME_BITS-1:0];
                end
                else
                begin
                    p_we      = 1'b1;
                    p_waddr   = p_wp_reg;
                    p_wp_next = p_wp_inc;
                    kept_next = kept_reg + 1'b1;
                end
            end
            // RTT filter on the shared multiplier
            ST_R_DIFF:
            begin
                dir_next  = (DW'(age_reg) >= DW'(rtt_reg));
                diff_next = (DW'(age_reg) >= DW'(rtt_reg)) ? DW'(age_reg) - DW'(rtt_reg)
                                                           : DW'(rtt_reg) - DW'(age_reg);
            end
            ST_R_MUL:
            begin
                prod_next = (DW+16)'(diff_reg) * (DW+16)'(gain_reg);
            end
            ST_R_APPLY:
            begin
                rtt_next   = (rtt_sum > (DW+1)'(RTT_MAX)) ? RTT_MAX : 24'(rtt_sum);
                acked_next = acked_reg + 32'd1;
            end
            ST_T_S_RD:
            begin
                if (walk_reg == n_reg)
                begin
                    walk_next     = '0;
                    n_next        = WW'(pend_count_reg);
                    p_rp_next     = pend_head_reg;
                    dropping_next = 1'b1;
                end
            end
            // age sent entries, drop the stale front, sum the rest
            ST_T_S_PROC:
            begin
                walk_next = walk_reg + 1'b1;
                s_rp_next = s_rp_inc;
                if (dropping_reg && (DW'(s_age_new) > DW'(window_reg)))
                begin
                    sent_head_next  = s_head_inc;
                    sent_count_next = sent_count_reg - 1'b1;
                end
                else
                begin
                    dropping_next = 1'b0;
                    s_we          = 1'b1;
                    s_wdata       = {s_rdata[SW-1:TIME_BITS+17], s_age_new, s_rdata[16:0]};
                    bytes_next    = (bytes_add > 24'(BYTES_MAX)) ? BYTES_MAX : 23'(bytes_add);
                end
            end
            // age pending entries, count timed-out front as lost
            ST_T_P_PROC:
            begin
                walk_next = walk_reg + 1'b1;
                p_rp_next = p_rp_inc;
                if (dropping_reg && (DW'(p_age_new) > DW'(timeout_reg)))
                begin
                    pend_head_next  = p_head_inc;
                    pend_count_next = pend_count_reg - 1'b1;
                    lost_tick_next  = lost_tick_reg + 1'b1;
                    lost_next       = lost_reg + 32'd1;
                end
                else
                begin
                    dropping_next = 1'b0;
                    p_we          = 1'b1;
                    p_waddr       = p_rp_reg;
                    p_wdata       = {p_rdata[PW-1:TIME_BITS], p_age_new};
                end
            end
            ST_T_P_RD:
            begin
                r_rp_next = r_last;
            end
            ST_T_RL_PROC:
            begin
                floor_next = r_rdata - PRUNE_DISTANCE;
                r_rp_next  = recv_head_reg;
            end
            // prune received entries at or below the floor
            ST_T_R_PROC:
            begin
                if (r_drop)
                begin
                    recv_head_next  = r_head_inc;
                    recv_count_next = recv_count_reg - 1'b1;
                    r_rp_next       = r_rp_inc;
                end
            end
            // present the result for one cycle
            ST_FIN:
            begin
                done_next   = 1'b1;
                result_next = '0;
                unique case (cmd_t'(in_reg.command))
                    CMD_SEND:
                    begin
                        result_next.seq_out      = seq_cap_reg;
                        result_next.ack_out      = remote_seq_reg;
                        result_next.ack_bits_out = bits_reg;
                    end
                    CMD_RECV:
                    begin
                        result_next.seq_out         = in_reg.rx_sequence;
                        result_next.duplicate       = dup_reg;
                        result_next.payload_present = !dup_reg
                            && (in_reg.length_bytes > 16'(hdr_reg));
                    end
                    CMD_TICK:
                    begin
                        result_next.lost_this_tick = (PCW'(lost_tick_reg) > PCW'(COUNT_MAX))
                            ? COUNT_MAX : 7'(lost_tick_reg);
                        result_next.sent_bytes_window = bytes_reg;
                        result_next.sent_packets_window =
                            (SCW'(sent_count_reg) > SCW'(COUNT_MAX))
                            ? COUNT_MAX : 7'(sent_count_reg);
                    end
                    default: ;
                endcase
                result_next.rtt         = rtt_reg;
                result_next.acked_total = acked_reg;
                result_next.lost_total  = lost_reg;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            local_seq_reg  <= '0;
            remote_seq_reg <= '0;
            sent_head_reg  <= '0;
            sent_count_reg <= '0;
            pend_head_reg  <= '0;
            pend_count_reg <= '0;
            recv_head_reg  <= '0;
            recv_count_reg <= '0;
            rtt_reg        <= '0;
            acked_reg      <= '0;
            lost_reg       <= '0;
            timeout_reg    <= 24'd511;
            window_reg     <= 24'd1025;
            hdr_reg        <= 8'd8;
            ovh_reg        <= 8'd8;
            gain_reg       <= 16'd6554;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            local_seq_reg  <= local_seq_next;
            remote_seq_reg <= remote_seq_next;
            sent_head_reg  <= sent_head_next;
            sent_count_reg <= sent_count_next;
            pend_head_reg  <= pend_head_next;
            pend_count_reg <= pend_count_next;
            recv_head_reg  <= recv_head_next;
            recv_count_reg <= recv_count_next;
            rtt_reg        <= rtt_next;
            acked_reg      <= acked_next;
            lost_reg       <= lost_next;
            timeout_reg    <= timeout_next;
            window_reg     <= window_next;
            hdr_reg        <= hdr_next;
            ovh_reg        <= ovh_next;
            gain_reg       <= gain_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        in_reg        <= in_next;
        seq_cap_reg   <= seq_cap_next;
        walk_reg      <= walk_next;
        n_reg         <= n_next;
        s_rp_reg      <= s_rp_next;
        p_rp_reg      <= p_rp_next;
        p_wp_reg      <= p_wp_next;
        r_rp_reg      <= r_rp_next;
        kept_reg      <= kept_next;
        dropping_reg  <= dropping_next;
        bits_reg      <= bits_next;
        dup_reg       <= dup_next;
        lost_tick_reg <= lost_tick_next;
        bytes_reg     <= bytes_next;
        floor_reg     <= floor_next;
        age_reg       <= age_next;
        dir_reg       <= dir_next;
        diff_reg      <= diff_next;
        prod_reg      <= prod_next;
    end

    a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sent_count_reg <= SCW'(SENT_DEPTH))
        else $error("sent queue count beyond depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_R_P_RD) |-> (WW'(kept_reg) <= walk_reg))
        else $error("pending compaction ran ahead of the read pointer");

endmodule
